/* src/linear_interp_resampler_macros.svh */
// ----------------------------------------------------------------------------
// Linear interpolation resampler assertion macros
// Concurrent checks clocked on clk, held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_INTERP_RESAMPLER_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_MACROS_SVH

`ifndef SYNTHESIS
`define LIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LIR_ASSERT_NOW(label, ante, cons, msg)
`define LIR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* src/lir_pkg.sv */
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Sequencer states, configuration register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package lir_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOP
    } state_t;

    localparam int CFG_INDEX_W     = 2;
    localparam int CHANNEL_COUNT_W = 4;
    localparam int OUT_CHANNEL_W   = 3;
    // wide enough to hold a channel count of up to 16
    localparam int COUNT_W         = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP          = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 2'd1;

endpackage

/* src/linear_interp_resampler.sv */
// First output of an accepted word: ST_READ, ST_LOOP, then the multiply and output registers.
// Each input word causes n outputs (0 to MAX_UPSAMPLE), one pass of the shared multiplier each;
//   a new input word is taken only after the history memory access and all outputs of the last.
// Two-stage multiply/round pipeline; outputs stream one word per cycle unless m_axis_tready stalls.
// Reset (rst_n low, asynchronous) clears phase, channel index and history valid bits;
//   step resets to 1.0 and channel_count to 1.
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Interpolates interleaved channels with a shared running phase; history per
// channel is held in a small synchronous memory.
// ----------------------------------------------------------------------------
`include "linear_interp_resampler_macros.svh"

module linear_interp_resampler
    import lir_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    parameter int FRAC_BITS    = 24,
    parameter int MAX_UPSAMPLE = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_INDEX_W-1:0]            cfg_index,
    input  logic [FRAC_BITS+4:0]              cfg_data,
    // input stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,  // in_sample
    // output stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [((SAMPLE_BITS+10)/8)*8-1:0] m_axis_tdata,  // out_sample, out_channel
    output logic                              m_axis_tlast
);

    localparam int PH_W   = FRAC_BITS + 5;
    localparam int PA_W   = PH_W + 1;
    localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int MUL_W  = DIFF_W + FRAC_BITS + 1;
    localparam int T_W    = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int Q_W    = SAMPLE_BITS + 2;
    localparam int OUT_W  = ((SAMPLE_BITS + 10) / 8) * 8;

    localparam longint MIN_STEP_L = ((longint'(1) << FRAC_BITS) + MAX_UPSAMPLE - 1) / MAX_UPSAMPLE;
    localparam logic [PH_W-1:0]  MIN_STEP   = PH_W'(MIN_STEP_L);
    localparam logic [PH_W-1:0]  STEP_RESET = PH_W'(1) << FRAC_BITS;
    localparam logic [PA_W-1:0]  PHASE_ONE  = PA_W'(1) << FRAC_BITS;
    localparam logic [COUNT_W-1:0] MAX_CNT  = COUNT_W'(MAX_CHANNELS);
    localparam logic signed [T_W-1:0] RND   = T_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0] SMAX  = Q_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [Q_W-1:0] SMIN  = -SMAX - Q_W'(1);

    // configuration
    logic [PH_W-1:0]            step_reg;
    logic [CHANNEL_COUNT_W-1:0] cc_reg;

    // sequencer and item state
    state_t                     state_reg, state_next;
    logic [PH_W-1:0]            frame_phase_reg;
    logic [CH_W-1:0]            ch_reg;
    logic [CH_W-1:0]            cur_ch_reg;
    logic                       last_ch_reg;
    logic signed [SAMPLE_BITS-1:0] cur_reg;
    logic signed [SAMPLE_BITS-1:0] prev_reg;
    logic signed [DIFF_W-1:0]   diff_reg;
    logic [PA_W-1:0]            phase_reg;
    logic [PH_W-1:0]            st_reg;

    // history memory
    logic [SAMPLE_BITS-1:0]     mem [MAX_CHANNELS];
    logic [MAX_CHANNELS-1:0]    mem_vld_reg;
    logic [SAMPLE_BITS-1:0]     rdata_reg;
    logic                       rd_vld_reg;

    // pipeline
    logic                       m1_valid_reg;
    logic signed [MUL_W-1:0]    m1_prod_reg;
    logic signed [SAMPLE_BITS-1:0] m1_prev_reg;
    logic [CH_W-1:0]            m1_ch_reg;
    logic                       m1_last_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_BITS-1:0]     out_sample_reg;
    logic [OUT_CHANNEL_W-1:0]   out_ch_reg;
    logic                       out_last_reg;

    // combinational
    logic                       accept;
    logic                       mem_wr;
    logic                       issue;
    logic                       done;
    logic                       pipe_en;
    logic                       phase_lt_one;
    logic [PA_W-1:0]            phase_sum;
    logic [COUNT_W-1:0]         cnt_eff;
    logic [COUNT_W-1:0]         last_ch;
    logic [COUNT_W-1:0]         ch_wide;
    logic [COUNT_W-1:0]         ch_eff_wide;
    logic [CH_W-1:0]            ch_eff;
    logic [PH_W-1:0]            st_eff;
    logic signed [SAMPLE_BITS-1:0] prev_rd;
    logic signed [DIFF_W-1:0]   diff_next;
    logic signed [FRAC_BITS:0]  frac_s;
    logic signed [MUL_W-1:0]    prod;
    logic signed [T_W-1:0]      t_sum;
    logic signed [T_W-1:0]      t_shift;
    logic signed [Q_W-1:0]      q_val;
    logic [SAMPLE_BITS-1:0]     y_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_RESET;
            cc_reg   <= CHANNEL_COUNT_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_STEP:          step_reg <= cfg_data;
                REG_CHANNEL_COUNT: cc_reg   <= cfg_data[CHANNEL_COUNT_W-1:0];
                default:           ;
            endcase
        end
    end

    // clamp the channel count, the current channel index and the step
    always_comb
    begin
        cnt_eff = COUNT_W'(cc_reg);
        if (cnt_eff == '0)
            cnt_eff = COUNT_W'(1);
        if (cnt_eff > MAX_CNT)
            cnt_eff = MAX_CNT;
        last_ch     = cnt_eff - COUNT_W'(1);
        ch_wide     = COUNT_W'(ch_reg);
        ch_eff_wide = (ch_wide >= cnt_eff) ? last_ch : ch_wide;
        ch_eff      = ch_eff_wide[CH_W-1:0];
        st_eff      = (step_reg < MIN_STEP) ? MIN_STEP : step_reg;
    end

    assign pipe_en      = !out_valid_reg || m_axis_tready;
    assign phase_lt_one = phase_reg < PHASE_ONE;
    assign phase_sum    = phase_reg + PA_W'(st_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_READ;
            ST_READ: state_next = ST_LOOP;
            ST_LOOP: if (!phase_lt_one) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        mem_wr        = 1'b0;
        issue         = 1'b0;
        done          = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_READ: mem_wr = 1'b1;
            ST_LOOP:
            begin
                issue = phase_lt_one && pipe_en;
                done  = !phase_lt_one;
            end
            default: ;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // history memory, registered read
    always_ff @(posedge clk)
    begin
        if (accept)
            rdata_reg <= mem[ch_eff];
        if (mem_wr)
            mem[cur_ch_reg] <= cur_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
                rd_vld_reg <= mem_vld_reg[ch_eff];
            if (mem_wr)
                mem_vld_reg[cur_ch_reg] <= 1'b1;
        end
    end

    // a channel never written reads as zero
    assign prev_rd   = rd_vld_reg ? $signed(rdata_reg) : '0;
    assign diff_next = DIFF_W'(cur_reg) - DIFF_W'(prev_rd);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_reg <= $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
            st_reg  <= st_eff;
        end
        if (mem_wr)
        begin
            prev_reg <= prev_rd;
            diff_reg <= diff_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_phase_reg <= '0;
            ch_reg          <= '0;
            cur_ch_reg      <= '0;
            last_ch_reg     <= 1'b0;
            phase_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                cur_ch_reg  <= ch_eff;
                last_ch_reg <= (ch_eff_wide == last_ch);
                phase_reg   <= PA_W'(frame_phase_reg);
            end
            else if (issue)
                phase_reg <= phase_sum;
            // at the end of the item advance the channel; after the last channel drop 1.0 from the phase
            if (done)
            begin
                if (last_ch_reg)
                begin
                    frame_phase_reg <= PH_W'(phase_reg - PHASE_ONE);
                    ch_reg          <= '0;
                end
                else
                    ch_reg <= cur_ch_reg + CH_W'(1);
            end
        end
    end

    // multiply stage
    assign frac_s = $signed({1'b0, phase_reg[FRAC_BITS-1:0]});
    assign prod   = diff_reg * frac_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (pipe_en)
            m1_valid_reg <= issue;
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            m1_prod_reg <= prod;
            m1_prev_reg <= prev_reg;
            m1_ch_reg   <= cur_ch_reg;
            m1_last_reg <= (phase_sum >= PHASE_ONE);
        end
    end

    // round half up, then saturate
    always_comb
    begin
        t_sum   = (T_W'(m1_prev_reg) <<< FRAC_BITS) + T_W'(m1_prod_reg) + RND;
        t_shift = t_sum >>> FRAC_BITS;
        q_val   = $signed(t_shift[Q_W-1:0]);
        if (q_val > SMAX)
            y_sat = SMAX[SAMPLE_BITS-1:0];
        else if (q_val < SMIN)
            y_sat = SMIN[SAMPLE_BITS-1:0];
        else
            y_sat = q_val[SAMPLE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (pipe_en)
            out_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && m1_valid_reg)
        begin
            out_sample_reg <= y_sat;
            out_ch_reg     <= OUT_CHANNEL_W'(m1_ch_reg);
            out_last_reg   <= m1_last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_ch_reg, out_sample_reg});
    assign m_axis_tlast  = out_last_reg;

    `LIR_ASSERT_NEXT(a_accept_reads, accept, state_reg == ST_READ, "accepted word did not start a read")
    `LIR_ASSERT_NOW(a_issue_below_one, issue, phase_reg < PHASE_ONE, "output issued at phase of 1.0 or more")
    `LIR_ASSERT_NEXT(a_done_to_idle, state_reg == ST_LOOP && !phase_lt_one, state_reg == ST_IDLE, "item did not finish")
    `LIR_ASSERT_NOW(a_channel_range, m1_valid_reg, 32'(m1_ch_reg) < MAX_CHANNELS, "channel index out of range")

endmodule
